// ===== rtl/tcd_pkg.sv =====
// Package: shared constants and register indexes for the thermistor current derater.
`default_nettype none
package tcd_pkg;
    localparam int POLY_TERMS_DEF = 4;
    localparam int ADC_BITS_DEF   = 12;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd7;
    localparam logic signed [23:0] LOWER_RST = 24'sd25600;
    localparam logic signed [23:0] UPPER_RST = 24'sd30720;
    localparam logic [15:0]        ALPHA_RST = 16'd8;
    localparam logic signed [24:0] TRIP_MARGIN = 25'sd1280;
endpackage
`default_nettype wire

// ===== rtl/tcd_serial_mul.sv =====
// Shift-and-add multiplier: signed multiplicand times unsigned multiplier, one bit per cycle.
`default_nettype none
module tcd_serial_mul #(
    parameter int AW = 32,
    parameter int BW = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [AW-1:0]  i_a,
    input  wire logic [BW-1:0]         i_b,
    output logic                       o_done,
    output logic signed [AW+BW-1:0]    o_prod
);
    localparam int CW = $clog2(BW + 1);
    logic                    r_busy, n_busy;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic signed [AW+BW-1:0] r_acc, n_acc;
    logic signed [AW+BW-1:0] r_a, n_a;
    logic [BW-1:0]           r_b, n_b;
    logic                    r_done, n_done;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(BW);
            n_acc  = '0;
            n_a    = (AW+BW)'(i_a);
            n_b    = i_b;
        end else if (r_busy) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a   = r_a <<< 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |-> (r_cnt != '0)) else $error("busy with zero count");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
`endif
endmodule
`default_nettype wire

// ===== rtl/tcd_serial_div.sv =====
// Restoring divider: unsigned numerator and denominator, one quotient bit per cycle.
`default_nettype none
module tcd_serial_div #(
    parameter int NW = 43,
    parameter int DW = 25
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quot
);
    localparam int CW = $clog2(NW + 1);
    logic            r_busy, n_busy;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [NW-1:0]   r_q, n_q;
    logic [DW:0]     r_rem, n_rem;
    logic [DW-1:0]   r_den, n_den;
    logic            r_done, n_done;
    logic [DW:0]     w_trial;
    logic [DW+1:0]   w_diff;

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        n_done  = 1'b0;
        w_trial = {r_rem[DW-1:0], r_q[NW-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NW);
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (!w_diff[DW+1]) begin
                n_rem = w_diff[DW:0];
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("div done while busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_den != '0) |-> (r_rem < {1'b0, r_den})) else $error("remainder too big");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("div done held");
`endif
endmodule
`default_nettype wire

// ===== rtl/thermistor_current_derater.sv =====
// Top level: thermistor polynomial, low-pass filter and linear current derating.
//
// Usage: an input transaction (i_adc_code, i_base_current) is taken on i_valid && o_ready.
// The block works on one item at a time; o_ready is high only while it is idle.
// Every multiply runs the 17-bit serial multiplier. Each Horner step is one multiply;
// the filter update is one more, skipped on the seeding item; then comes the check;
// the derating is a multiply plus a serial divide (43 quotient bits), and last comes
// the output write. Limiter disabled or zero range skips the multiply and divide.
// The result is held in an output register with o_valid until i_ready; the next item is
// taken while the result waits. Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data)
// take effect at once; the user must make them only while idle, and the block itself
// does not enforce this.
// Reset (i_rst_n low, synchronous) restores register defaults, clears the filter seed
// and the sticky over-temperature flag, and empties the output register.
// A stalled receiver holds the result; the block stops before writing a second one.
`default_nettype none
module thermistor_current_derater #(
    parameter int POLY_TERMS = tcd_pkg::POLY_TERMS_DEF,
    parameter int ADC_BITS   = tcd_pkg::ADC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tcd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [ADC_BITS-1:0]             i_adc_code,
    input  wire logic [17:0]                     i_base_current,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [23:0]                   o_filtered_temperature,
    output logic [17:0]                          o_current_limit,
    output logic                                 o_checks_pass,
    output logic                                 o_over_temp_error
);
    import tcd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HSTRT = 4'd1;
    localparam logic [3:0] S_HWAIT = 4'd2;
    localparam logic [3:0] S_FSTRT = 4'd3;
    localparam logic [3:0] S_FWAIT = 4'd4;
    localparam logic [3:0] S_DSTRT = 4'd5;
    localparam logic [3:0] S_DWAIT = 4'd6;
    localparam logic [3:0] S_VSTRT = 4'd7;
    localparam logic [3:0] S_VWAIT = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam int MW = 17;   // multiplier operand width (Q.16 x, alpha, base)
    localparam int KW = 2;

    logic signed [31:0] r_coeff [4];
    logic signed [23:0] r_lower, r_upper;
    logic               r_en;
    logic [15:0]        r_alpha;

    logic [3:0]          r_st, n_st;
    logic [ADC_BITS-1:0] r_code;
    logic [17:0]         r_base;
    logic [KW-1:0]       r_k, n_k;
    logic signed [31:0]  r_acc, n_acc;
    logic signed [39:0]  r_faccum, n_faccum;
    logic                r_seeded, n_seeded;
    logic                r_latch, n_latch;
    logic signed [24:0]  r_margin, n_margin;
    logic signed [24:0]  r_range, n_range;
    logic signed [42:0]  r_prod, n_prod;
    logic [17:0]         r_lim, n_lim;
    logic                r_pass, n_pass;
    logic                r_ovalid, n_ovalid;
    logic signed [23:0]  r_otemp, n_otemp;
    logic [17:0]         r_olim, n_olim;
    logic                r_opass, n_opass;
    logic                r_oerr, n_oerr;

    logic               w_mstart;
    logic signed [41:0] w_ma;
    logic [MW-1:0]      w_mb;
    logic               w_mdone;
    logic signed [41+MW:0] w_mprod;
    logic               w_dstart;
    logic [42:0]        w_dnum;
    logic [24:0]        w_dden;
    logic               w_ddone;
    logic [42:0]        w_dquot;

    logic signed [48:0] w_hsum;
    logic signed [23:0] w_raw;
    logic signed [41:0] w_diff;
    logic signed [23:0] w_temp;
    logic signed [24:0] w_lim_q;
    logic               w_neg;
    logic [42:0]        w_pabs;
    logic [24:0]        w_rabs;
    logic signed [43:0] w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_coeff[i] <= '0;
            r_lower <= LOWER_RST;
            r_upper <= UPPER_RST;
            r_en    <= 1'b0;
            r_alpha <= ALPHA_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COEFF_0: r_coeff[0] <= i_cfg_data;
                REG_COEFF_1: r_coeff[1] <= i_cfg_data;
                REG_COEFF_2: r_coeff[2] <= i_cfg_data;
                REG_COEFF_3: r_coeff[3] <= i_cfg_data;
                REG_LOWER:   r_lower    <= i_cfg_data[23:0];
                REG_UPPER:   r_upper    <= i_cfg_data[23:0];
                REG_ENABLE:  r_en       <= i_cfg_data[0];
                REG_ALPHA:   r_alpha    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    tcd_serial_mul #(.AW(42), .BW(MW)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(w_ma), .i_b(w_mb), .o_done(w_mdone), .o_prod(w_mprod)
    );

    tcd_serial_div #(.NW(43), .DW(25)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quot(w_dquot)
    );

    assign o_ready = (r_st == S_IDLE);

    always_comb begin
        // Horner step: floor(acc*x/2^16) + coeff, saturated
        w_hsum   = 49'(w_mprod >>> 16) + 49'(r_coeff[r_k]);
        w_raw    = 24'(r_acc >>> 8);
        // 42 bits: the difference of two 40-bit values needs 41
        w_diff   = 42'($signed({w_raw, 16'h0})) - 42'(r_faccum);
        w_temp   = 24'(r_faccum >>> 16);
        w_neg    = r_prod[42] ^ r_range[24];
        w_pabs   = r_prod[42] ? 43'(-r_prod) : 43'(r_prod);
        w_rabs   = r_range[24] ? 25'(-r_range) : 25'(r_range);
        w_q      = w_neg ? -44'(w_dquot) : 44'(w_dquot);
        if (w_q < 0) w_lim_q = '0;
        else if (w_q > 44'(r_base)) w_lim_q = 25'(r_base);
        else w_lim_q = 25'(w_q);

        w_mstart = 1'b0;
        w_ma     = 42'(r_acc);
        w_mb     = MW'(r_code) << (16 - ADC_BITS);
        w_dstart = 1'b0;
        w_dnum   = w_pabs;
        w_dden   = w_rabs;

        n_st = r_st; n_k = r_k; n_acc = r_acc; n_faccum = r_faccum;
        n_seeded = r_seeded; n_latch = r_latch; n_margin = r_margin;
        n_range = r_range; n_prod = r_prod; n_ovalid = r_ovalid;
        n_lim = r_lim; n_pass = r_pass;
        n_otemp = r_otemp; n_olim = r_olim; n_opass = r_opass; n_oerr = r_oerr;

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        case (r_st)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_acc = r_coeff[0];
                    n_k   = KW'(1);
                    n_st  = (POLY_TERMS > 1) ? S_HSTRT : S_FSTRT;
                end
            end
            S_HSTRT: begin
                w_mstart = 1'b1;
                n_st = S_HWAIT;
            end
            S_HWAIT: begin
                if (w_mdone) begin
                    if (w_hsum > 49'sd2147483647) n_acc = 32'h7FFFFFFF;
                    else if (w_hsum < -49'sd2147483648) n_acc = 32'h80000000;
                    else n_acc = 32'(w_hsum);
                    if (32'(r_k) + 1 >= POLY_TERMS) n_st = S_FSTRT;
                    else begin
                        n_k  = r_k + 1'b1;
                        n_st = S_HSTRT;
                    end
                end
            end
            S_FSTRT: begin
                if (!r_seeded) begin
                    n_faccum = {w_raw, 16'h0};
                    n_seeded = 1'b1;
                    n_st     = S_DSTRT;
                end else begin
                    w_ma     = w_diff;
                    w_mb     = MW'(r_alpha);
                    w_mstart = 1'b1;
                    n_st     = S_FWAIT;
                end
            end
            S_FWAIT: begin
                if (w_mdone) begin
                    n_faccum = r_faccum + 40'(w_mprod >>> 16);
                    n_st = S_DSTRT;
                end
            end
            S_DSTRT: begin
                n_margin = 25'(r_upper) - 25'(w_temp);
                n_range  = 25'(r_upper) - 25'(r_lower);
                n_pass   = 1'b1;
                if (r_en && (25'(w_temp) >= 25'(r_upper) + TRIP_MARGIN)) begin
                    n_latch = 1'b1;
                    n_pass  = 1'b0;
                end
                n_st = S_VSTRT;
            end
            S_VSTRT: begin
                if (!r_en) begin
                    n_lim = r_base;
                    n_st  = S_OUT;
                end else if (r_range == '0) begin
                    n_lim = (r_margin > 0) ? r_base : '0;
                    n_st  = S_OUT;
                end else begin
                    w_ma     = 42'(r_margin);
                    w_mb     = MW'(r_base[16:0]);
                    w_mstart = 1'b1;
                    n_st     = S_VWAIT;
                end
            end
            S_VWAIT: begin
                // base is 18 bits; add the top bit's share after the 17-bit multiply
                if (w_mdone) begin
                    n_prod = 43'(w_mprod) + (r_base[17] ? (43'(r_margin) <<< 17) : '0);
                    w_dstart = 1'b0;
                    n_st = S_DWAIT;
                    n_k  = '0;
                end
            end
            S_DWAIT: begin
                if (r_k == '0) begin
                    w_dstart = 1'b1;
                    n_k = KW'(1);
                end else if (w_ddone) begin
                    n_lim = 18'(w_lim_q);
                    n_st  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_otemp  = w_temp;
                    n_olim   = r_lim;
                    n_opass  = r_pass;
                    n_oerr   = r_latch;
                    n_st     = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_k      <= '0;
            r_faccum <= '0;
            r_seeded <= 1'b0;
            r_latch  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_k      <= n_k;
            r_faccum <= n_faccum;
            r_seeded <= n_seeded;
            r_latch  <= n_latch;
            r_ovalid <= n_ovalid;
        end
        if (i_valid && o_ready) begin
            r_code <= i_adc_code;
            r_base <= i_base_current;
        end
        r_acc    <= n_acc;
        r_margin <= n_margin;
        r_range  <= n_range;
        r_prod   <= n_prod;
        r_lim    <= n_lim;
        r_pass   <= n_pass;
        r_otemp  <= n_otemp;
        r_olim   <= n_olim;
        r_opass  <= n_opass;
        r_oerr   <= n_oerr;
    end

    assign o_valid                = r_ovalid;
    assign o_filtered_temperature = r_otemp;
    assign o_current_limit        = r_olim;
    assign o_checks_pass          = r_opass;
    assign o_over_temp_error      = r_oerr;

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_st != S_IDLE)) else $error("accept did not start");
    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latch |=> r_latch) else $error("over-temp latch dropped");
    a_fail_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_opass) |-> r_latch) else $error("fail without latch");
    a_lim_le_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |-> (r_lim <= r_base)) else $error("limit above base");
`endif
endmodule
`default_nettype wire

// ===== tb/thermistor_current_derater_tb.sv =====
// Testbench for thermistor_current_derater: queue-fed driver, predicting monitor.
`timescale 1ns / 1ps
module thermistor_current_derater_tb;
    import tcd_pkg::*;

    typedef struct packed {
        logic [11:0] code;
        logic [17:0] base;
    } sample_t;

    typedef struct packed {
        logic signed [23:0] temp;
        logic [17:0]        limit;
        logic               pass;
        logic               err;
    } derate_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [11:0] i_adc_code = '0;
    logic [17:0] i_base_current = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [23:0] o_filtered_temperature;
    logic [17:0] o_current_limit;
    logic o_checks_pass;
    logic o_over_temp_error;

    thermistor_current_derater u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] coeff [4];
    logic signed [23:0] lim_lo, lim_hi;
    logic               lim_en;
    logic [15:0]        alpha;
    longint             filt_acc;
    bit                 seeded, ot_latch;

    sample_t pending_samples [$];
    derate_t expected_results [$];
    int send_idle_pct = 0, recv_idle_pct = 0;
    int recv_hold = 0;
    int mismatches = 0, stall_cycles = 0;
    bit failed = 0;

    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic derate_t predict_derating(sample_t s);
        derate_t r;
        longint x, acc, raw, t, lim, margin, range, b;
        x = longint'(s.code) << 4;
        b = longint'(s.base);
        acc = coeff[0];
        for (int i = 1; i < 4; i++) acc = sat32(floor_shr(acc * x, 16) + longint'(coeff[i]));
        raw = floor_shr(acc, 8);
        if (!seeded) begin
            filt_acc = raw * 65536;
            seeded = 1;
        end else begin
            filt_acc += floor_shr(longint'(alpha) * (raw * 65536 - filt_acc), 16);
        end
        t = floor_shr(filt_acc, 16);
        r.pass = 1'b1;
        if (lim_en && t >= longint'(lim_hi) + 1280) begin
            ot_latch = 1;
            r.pass = 1'b0;
        end
        if (!lim_en) lim = b;
        else begin
            margin = longint'(lim_hi) - t;
            range = longint'(lim_hi) - longint'(lim_lo);
            if (range == 0) lim = (margin > 0) ? b : 0;
            else begin
                lim = (b * margin) / range;
                if (lim < 0) lim = 0;
                if (lim > b) lim = b;
            end
        end
        r.temp = t[23:0];
        r.limit = lim[17:0];
        r.err = ot_latch;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            expected_results.push_back(predict_derating({i_adc_code, i_base_current}));
        end
        if (!i_valid || o_ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                sample_t s;
                s = pending_samples.pop_front();
                i_valid <= 1'b1;
                i_adc_code <= s.code;
                i_base_current <= s.base;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            derate_t got, want;
            got = {o_filtered_temperature, o_current_limit, o_checks_pass, o_over_temp_error};
            if (expected_results.size() == 0) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
                end
            end
        end
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_COEFF_0: coeff[0] = val;
            REG_COEFF_1: coeff[1] = val;
            REG_COEFF_2: coeff[2] = val;
            REG_COEFF_3: coeff[3] = val;
            REG_LOWER:   lim_lo = val[23:0];
            REG_UPPER:   lim_hi = val[23:0];
            REG_ENABLE:  lim_en = val[0];
            default:     alpha = val[15:0];
        endcase
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // typical NTC-like curve so the filtered value sweeps the derating band
    task automatic load_curve();
        write_reg(REG_COEFF_0, $urandom_range(400000) - 200000);
        write_reg(REG_COEFF_1, $urandom_range(2000000) - 1000000);
        write_reg(REG_COEFF_2, $urandom_range(16000000) - 8000000);
        write_reg(REG_COEFF_3, $urandom_range(8000000));
    endtask

    task automatic queue_random(int n);
        sample_t s;
        repeat (n) begin
            s.code = $urandom_range(4095);
            case ($urandom_range(3))
                0: s.base = 18'h3FFFF;
                1: s.base = '0;
                default: s.base = $urandom_range(262143);
            endcase
            pending_samples.push_back(s);
        end
    endtask

    initial begin
        coeff = '{default: '0};
        lim_lo = LOWER_RST;
        lim_hi = UPPER_RST;
        lim_en = 1'b0;
        alpha = ALPHA_RST;
        filt_acc = 0;
        seeded = 0;
        ot_latch = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, then enabled with extremes
        pending_samples.push_back({12'd0, 18'd0});
        pending_samples.push_back({12'hFFF, 18'h3FFFF});
        drain();
        write_reg(REG_COEFF_0, 32'h7FFFFFFF);  // saturation high
        write_reg(REG_COEFF_1, 32'h7FFFFFFF);
        write_reg(REG_COEFF_2, 32'h7FFFFFFF);
        write_reg(REG_COEFF_3, 32'h7FFFFFFF);
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_ALPHA, 32'hFFFF);
        pending_samples.push_back({12'hFFF, 18'h3FFFF});  // trips, latch set
        pending_samples.push_back({12'd0, 18'h3FFFF});
        drain();
        write_reg(REG_COEFF_0, 32'h80000000);  // saturation low
        write_reg(REG_COEFF_1, 32'h80000000);
        write_reg(REG_COEFF_2, 32'h80000000);
        write_reg(REG_COEFF_3, 32'h80000000);
        write_reg(REG_ALPHA, 32'd0);
        pending_samples.push_back({12'hFFF, 18'h2AAAA});
        pending_samples.push_back({12'h555, 18'h15555});
        drain();
        write_reg(REG_LOWER, 32'h007FFFFF);     // lower above upper
        write_reg(REG_UPPER, 32'h00800000);
        write_reg(REG_COEFF_3, 32'h00200000);
        write_reg(REG_ALPHA, 32'd65535);
        pending_samples.push_back({12'h800, 18'h3FFFF});
        drain();
        write_reg(REG_LOWER, 32'd7680);         // zero range
        write_reg(REG_UPPER, 32'd7680);
        pending_samples.push_back({12'h001, 18'h3FFFF});
        drain();
        write_reg(REG_COEFF_0, 32'd0);
        write_reg(REG_COEFF_1, 32'd0);
        write_reg(REG_COEFF_2, 32'd0);
        write_reg(REG_COEFF_3, 32'd7680 << 8);
        drain();
        pending_samples.push_back({12'h002, 18'h3FFFF});
        drain();

        // random phases across settings and idle profiles
        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 29 : (ph < 6) ? 76 : 0;
            recv_idle_pct = (ph < 3) ? 76 : (ph < 6) ? 29 : 0;
            load_curve();
            write_reg(REG_LOWER, $urandom_range(16000));
            write_reg(REG_UPPER, $urandom_range(16000) + 8000);
            write_reg(REG_ENABLE, (ph % 4) != 3);
            write_reg(REG_ALPHA, (ph == 4) ? 65535 : (ph == 5) ? 0 : $urandom_range(65535));
            if (ph == 2) recv_hold = 2000;  // long receiver hold-off, input backs up
            queue_random(105);
            drain();
        end
        if (!failed && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
